[hdl/mec_pkg.sv]
package mec_pkg;

  // Register indexes of the configuration port.
  localparam int unsigned CFG_IDX_W    = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 8'd1;

  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned EXP_BITS     = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned OUT_W        = 32;
  localparam int unsigned MOD_WIDTH_DEF = 32;

  localparam logic [CFG_DATA_W-1:0] MODULUS_RST  = 32'd2;
  localparam logic [CFG_DATA_W-1:0] EXPONENT_RST = 32'd1;

endpackage

[hdl/modular_exponentiation_cipher_core.sv]
// Modular exponentiation cipher core: every input transaction carries one
// plaintext byte and yields one result transaction holding that byte raised
// to the configured exponent, reduced modulo the configured modulus (a
// modulus of zero gives zero). The datapath is a chain of cells, one
// register stage each: 8 cells reduce the byte modulo the modulus, then each
// of the 32 exponent bits passes through a squaring and a conditional
// multiplication, each of which is MOD_WIDTH add-and-double cells. Each item
// leaving the last cell is written into the output buffer and presented on
// the result stream in the following cycle. A new item is accepted in every
// cycle while the two-entry output buffer has room; when it is full the
// whole chain holds still until the consumer takes a transaction.
// Configuration is written through the cfg_ port (index 0 modulus, 1
// exponent); the user must write it only while no transaction is in
// flight, which the core itself does not enforce. Writes to other indexes
// are ignored.
module modular_exponentiation_cipher_core #(
  parameter int unsigned MOD_WIDTH = mec_pkg::MOD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream. in_tdata: plain_byte [7:0].
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mec_pkg::BYTE_W-1:0]       in_tdata,
  // Result stream. out_tdata: cipher_value [31:0].
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mec_pkg::OUT_W-1:0]        out_tdata,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mec_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned RED_N = mec_pkg::BYTE_W;
  localparam int unsigned MUL_N = mec_pkg::EXP_BITS * 2 * MOD_WIDTH;

  logic [MOD_WIDTH-1:0]              modulus_r;
  logic [mec_pkg::EXP_BITS-1:0]      exponent_r;
  logic                              en;

  // Configuration registers are always ready to take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= MOD_WIDTH'(mec_pkg::MODULUS_RST);
      exponent_r <= mec_pkg::EXP_BITS'(mec_pkg::EXPONENT_RST);
    end else if (cfg_valid) begin
      if (cfg_index == mec_pkg::REG_MODULUS) begin
        modulus_r <= MOD_WIDTH'(cfg_data);
      end else if (cfg_index == mec_pkg::REG_EXPONENT) begin
        exponent_r <= mec_pkg::EXP_BITS'(cfg_data);
      end
    end
  end

  // Byte reduction chain.
  logic [RED_N:0]                      rv;
  logic [RED_N:0][mec_pkg::BYTE_W-1:0] rbyte;
  logic [RED_N:0][MOD_WIDTH-1:0]       rr;

  assign in_tready = en;
  assign rv[0]     = in_tvalid;
  assign rbyte[0]  = in_tdata;
  assign rr[0]     = '0;

  for (genvar k = 0; k < RED_N; k++) begin : g_red
    mec_red_cell #(
      .MOD_WIDTH (MOD_WIDTH),
      .BIT_POS   (RED_N - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .m         (modulus_r),
      .in_valid  (rv[k]),
      .in_byte   (rbyte[k]),
      .in_r      (rr[k]),
      .out_valid (rv[k+1]),
      .out_byte  (rbyte[k+1]),
      .out_r     (rr[k+1])
    );
  end

  // Square-and-multiply chain. The running power starts at 1 mod m.
  logic [MUL_N:0]                mv;
  logic [MUL_N:0][MOD_WIDTH-1:0] mbase, macc, mmacc, mma, mmb;

  assign mv[0]    = rv[RED_N];
  assign mbase[0] = rr[RED_N];
  assign macc[0]  = (modulus_r == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
  assign mmacc[0] = '0;
  assign mma[0]   = '0;
  assign mmb[0]   = '0;

  for (genvar t = 0; t < mec_pkg::EXP_BITS; t++) begin : g_bit
    for (genvar ph = 0; ph < 2; ph++) begin : g_phase
      for (genvar k = 0; k < MOD_WIDTH; k++) begin : g_step
        localparam int unsigned S = (t * 2 + ph) * MOD_WIDTH + k;
        mec_mul_cell #(
          .MOD_WIDTH (MOD_WIDTH),
          .FIRST     (k == 0),
          .LAST      (k == MOD_WIDTH - 1),
          .IS_SQUARE (ph == 0)
        ) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .en        (en),
          .m         (modulus_r),
          .exp_bit   (exponent_r[mec_pkg::EXP_BITS - 1 - t]),
          .in_valid  (mv[S]),
          .in_base   (mbase[S]),
          .in_acc    (macc[S]),
          .in_macc   (mmacc[S]),
          .in_ma     (mma[S]),
          .in_mb     (mmb[S]),
          .out_valid (mv[S+1]),
          .out_base  (mbase[S+1]),
          .out_acc   (macc[S+1]),
          .out_macc  (mmacc[S+1]),
          .out_ma    (mma[S+1]),
          .out_mb    (mmb[S+1])
        );
      end
    end
  end

  // A zero modulus answers zero; the value is then narrowed to the result width.
  logic [63:0]                 result_wide;
  logic [mec_pkg::OUT_W-1:0]   result;

  assign result_wide = (modulus_r == '0) ? 64'd0 : 64'(macc[MUL_N]);
  assign result      = result_wide[mec_pkg::OUT_W-1:0];

  // The chain advances whenever the output buffer can take a transaction.
  mec_out_buf #(
    .DATA_W (mec_pkg::OUT_W)
  ) u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (mv[MUL_N]),
    .push_ready (en),
    .push_data  (result),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (out_tdata)
  );

`ifndef SYNTH
  a_below_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && modulus_r != '0 && MOD_WIDTH <= mec_pkg::OUT_W)
      |-> (64'(out_tdata) < 64'(modulus_r)))
    else $error("result not below the modulus");
  a_exp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && exponent_r == '0 && modulus_r > MOD_WIDTH'(1))
      |-> (out_tdata == mec_pkg::OUT_W'(1)))
    else $error("zero exponent did not give one");
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result presented straight after reset");
`endif

endmodule

[hdl/mec_red_cell.sv]
// One step of restoring reduction of the plaintext byte: r = (2r + bit) mod m.
module mec_red_cell #(
  parameter int unsigned MOD_WIDTH = mec_pkg::MOD_WIDTH_DEF,
  parameter int unsigned BIT_POS   = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [MOD_WIDTH-1:0]        m,
  input  logic                        in_valid,
  input  logic [mec_pkg::BYTE_W-1:0]  in_byte,
  input  logic [MOD_WIDTH-1:0]        in_r,
  output logic                        out_valid,
  output logic [mec_pkg::BYTE_W-1:0]  out_byte,
  output logic [MOD_WIDTH-1:0]        out_r
);

  logic                       valid_r;
  logic [mec_pkg::BYTE_W-1:0] byte_r;
  logic [MOD_WIDTH-1:0]       r_r;
  logic [MOD_WIDTH:0]         r_ext;
  logic [MOD_WIDTH:0]         r_sub;
  logic [MOD_WIDTH-1:0]       r_nxt;

  always_comb begin
    r_ext = {in_r, in_byte[BIT_POS]};
    r_sub = r_ext - {1'b0, m};
    r_nxt = (r_ext >= {1'b0, m}) ? r_sub[MOD_WIDTH-1:0] : r_ext[MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byte_r <= in_byte;
      r_r    <= r_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_r     = r_r;

endmodule

[hdl/mec_mul_cell.sv]
// One add-and-double step of a modular multiplication. A first cell takes
// the running power twice to square, else it and the base (1 for a clear
// exponent bit); the last hands the product back as the new running power.
module mec_mul_cell #(
  parameter int unsigned MOD_WIDTH = mec_pkg::MOD_WIDTH_DEF,
  parameter bit          FIRST     = 1'b0,
  parameter bit          LAST      = 1'b0,
  parameter bit          IS_SQUARE = 1'b1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [MOD_WIDTH-1:0] m,
  input  logic                 exp_bit,
  input  logic                 in_valid,
  input  logic [MOD_WIDTH-1:0] in_base,
  input  logic [MOD_WIDTH-1:0] in_acc,
  input  logic [MOD_WIDTH-1:0] in_macc,
  input  logic [MOD_WIDTH-1:0] in_ma,
  input  logic [MOD_WIDTH-1:0] in_mb,
  output logic                 out_valid,
  output logic [MOD_WIDTH-1:0] out_base,
  output logic [MOD_WIDTH-1:0] out_acc,
  output logic [MOD_WIDTH-1:0] out_macc,
  output logic [MOD_WIDTH-1:0] out_ma,
  output logic [MOD_WIDTH-1:0] out_mb
);

  logic                 valid_r;
  logic [MOD_WIDTH-1:0] base_r, acc_r, macc_r, ma_r, mb_r;
  logic [MOD_WIDTH-1:0] a_op, b_op, c_op;
  logic [MOD_WIDTH-1:0] c_nxt, a_nxt, b_nxt, acc_nxt;

  // (x + y) mod m for x, y below m, with no carry out of the word.
  function automatic logic [MOD_WIDTH-1:0] add_mod(input logic [MOD_WIDTH-1:0] x,
                                                   input logic [MOD_WIDTH-1:0] y,
                                                   input logic [MOD_WIDTH-1:0] md);
    logic [MOD_WIDTH-1:0] room;
    room = md - y;
    if (x >= room) begin
      return x - room;
    end
    return x + y;
  endfunction

  always_comb begin
    if (FIRST) begin
      a_op = in_acc;
      c_op = '0;
      if (IS_SQUARE) begin
        b_op = in_acc;
      end else begin
        b_op = exp_bit ? in_base : MOD_WIDTH'(1);
      end
    end else begin
      a_op = in_ma;
      b_op = in_mb;
      c_op = in_macc;
    end
    c_nxt   = b_op[0] ? add_mod(c_op, a_op, m) : c_op;
    a_nxt   = add_mod(a_op, a_op, m);
    b_nxt   = b_op >> 1;
    acc_nxt = LAST ? c_nxt : in_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r <= in_base;
      acc_r  <= acc_nxt;
      macc_r <= c_nxt;
      ma_r   <= a_nxt;
      mb_r   <= b_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_base  = base_r;
  assign out_acc   = acc_r;
  assign out_macc  = macc_r;
  assign out_ma    = ma_r;
  assign out_mb    = mb_r;

endmodule

[hdl/mec_out_buf.sv]
// Two-entry output buffer that decouples the cell chain from the consumer.
module mec_out_buf #(
  parameter int unsigned DATA_W = mec_pkg::OUT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  logic [1:0]        count_r;
  logic [DATA_W-1:0] head_r, tail_r;
  logic              push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else if (push && !pop) begin
      count_r <= count_r + 2'd1;
    end else if (pop && !push) begin
      count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          head_r <= push_data;
        end else begin
          tail_r <= push_data;
        end
      end
      2'b01: begin
        head_r <= tail_r;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          head_r <= push_data;
        end else begin
          head_r <= tail_r;
          tail_r <= push_data;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("output buffer count out of range");
  a_pop_moves_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && count_r == 2'd2) |=> (head_r == $past(tail_r)))
    else $error("output buffer lost its second entry");
  a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2 && !pop_ready) |=> (count_r == 2'd2))
    else $error("output buffer drained without a pop");
`endif

endmodule
